FILE: design/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg - shared definitions for the PS/2 mouse packet cursor core
// Register indexes, reset values, button byte codes and press codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

   // Default width of a cursor coordinate
   localparam int PMC_COORD_WIDTH = 12;

   // Size registers
   localparam int SIZE_WIDTH = 13;
   localparam int CSR_ADDR_WIDTH = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [SIZE_WIDTH-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_WIDTH-1:0] SCREEN_HEIGHT_RESET = 13'd480;

   // Margins taken off the screen size to give the clamp limits
   localparam int PMC_X_MARGIN = 2;
   localparam int PMC_Y_MARGIN = 20;

   // Position of a byte within a three-byte packet
   localparam logic [1:0] BYTE_STATUS = 2'd0;
   localparam logic [1:0] BYTE_MOVE_X = 2'd1;
   localparam logic [1:0] BYTE_MOVE_Y = 2'd2;

   // Whole status byte values that select a press code
   localparam logic [7:0] STATUS_LEFT   = 8'd9;
   localparam logic [7:0] STATUS_RIGHT  = 8'd10;
   localparam logic [7:0] STATUS_MIDDLE = 8'd12;

   // Press codes
   localparam logic [1:0] PRESS_NONE   = 2'd0;
   localparam logic [1:0] PRESS_LEFT   = 2'd1;
   localparam logic [1:0] PRESS_RIGHT  = 2'd2;
   localparam logic [1:0] PRESS_MIDDLE = 2'd3;

   // Signed movement, wide enough to hold the negated Y byte
   typedef logic signed [8:0] delta_type;

endpackage

`default_nettype wire

FILE: design/ps2_mouse_packet_cursor_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_core - PS/2 mouse packet decoder with cursor
// Gathers mouse bytes into three-byte packets and keeps a clamped cursor
// and a button press code.
// ----------------------------------------------------------------------------
// Bytes arrive on the req stream with the aux flag in tuser; bytes without
// the flag are dropped. Every third mouse byte closes a packet and gives
// one item on the rsp stream: the cursor after the packet's movement,
// clamped to 0..screen_width-2 and 0..screen_height-20, the press code and
// the three button bits. One byte is taken every cycle unless a closing
// byte stalls; a result passes through the input register, then the result
// register. The rsp register lets the next bytes in while a result waits;
// only a closing byte stalls, and only while that register is full and not
// being read. The user must write screen sizes through the csr port only
// while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_cursor_core
   import pmc_pkg::*;
#(
   parameter int COORD_WIDTH = PMC_COORD_WIDTH,
   localparam int RspBits  = 2 * COORD_WIDTH + 5,
   localparam int RspWidth = ((RspBits + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   // Mouse bytes
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] data_byte
   input  wire logic                      req_tuser,   // [0] aux_flag

   // Packet results
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [RspWidth-1:0]       rsp_tdata,   // cursor_x, cursor_y,
                                                       // press_code, button_bits

   // Register writes
   input  wire logic                      csr_we,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [SIZE_WIDTH-1:0]     csr_wdata
);

   // Size registers
   logic [SIZE_WIDTH-1:0] width_ff, height_ff;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_aux_ff;
   logic [7:0] s1_byte_ff;

   // Packet state
   logic [1:0]             byte_index_ff, byte_index_in;
   logic [7:0]             b0_ff, b1_ff;
   logic [COORD_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic [COORD_WIDTH-1:0] pos_y_ff, pos_y_in;
   logic [2:0]             old_buttons_ff, old_buttons_in;
   logic [1:0]             press_ff, press_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspWidth-1:0] rsp_data_ff;

   logic                   out_free, closes, s1_go, take;
   logic [COORD_WIDTH-1:0] axis_x, axis_y;
   delta_type              delta_x, delta_y;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: a closing byte needs room in the result register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign closes     = s1_aux_ff && (byte_index_ff == BYTE_MOVE_Y);
   assign s1_go      = s1_valid_ff && (!closes || out_free);
   assign take       = s1_go && s1_aux_ff;
   assign req_tready = !s1_valid_ff || s1_go;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_aux_ff  <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
   end

   // Movement from bytes 1 and 2; Y axis runs the other way
   assign delta_x = {b1_ff[7], b1_ff};
   assign delta_y = -$signed({s1_byte_ff[7], s1_byte_ff});

   pmc_axis #(
      .CoordWidth (COORD_WIDTH),
      .Margin     (PMC_X_MARGIN)
   ) u_axis_x (
      .pos_i   (pos_x_ff),
      .delta_i (delta_x),
      .size_i  (width_ff),
      .pos_o   (axis_x)
   );

   pmc_axis #(
      .CoordWidth (COORD_WIDTH),
      .Margin     (PMC_Y_MARGIN)
   ) u_axis_y (
      .pos_i   (pos_y_ff),
      .delta_i (delta_y),
      .size_i  (height_ff),
      .pos_o   (axis_y)
   );

   // Packet update
   always_comb begin
      byte_index_in  = byte_index_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      old_buttons_in = old_buttons_ff;
      press_in       = press_ff;
      if (take) begin
         if (byte_index_ff == BYTE_MOVE_Y) begin
            byte_index_in = BYTE_STATUS;
            // No movement leaves the cursor as it is
            if (b1_ff != 8'd0 || s1_byte_ff != 8'd0) begin
               pos_x_in = axis_x;
               pos_y_in = axis_y;
            end
            // Button bits in order, a later bit overriding an earlier one
            for (int i = 0; i < 3; i++) begin
               if (b0_ff[i] != old_buttons_ff[i]) begin
                  if (old_buttons_ff[i]) begin
                     press_in = PRESS_NONE;
                  end else if (b0_ff == STATUS_LEFT) begin
                     press_in = PRESS_LEFT;
                  end else if (b0_ff == STATUS_RIGHT) begin
                     press_in = PRESS_RIGHT;
                  end else if (b0_ff == STATUS_MIDDLE) begin
                     press_in = PRESS_MIDDLE;
                  end
               end
            end
            old_buttons_in = b0_ff[2:0];
         end else if (byte_index_ff == BYTE_STATUS) begin
            byte_index_in = BYTE_MOVE_X;
         end else if (byte_index_ff == BYTE_MOVE_X) begin
            byte_index_in = BYTE_MOVE_Y;
         end else begin
            // Unused index acts as the status byte
            byte_index_in = BYTE_MOVE_X;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= BYTE_STATUS;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         old_buttons_ff <= '0;
         press_ff       <= PRESS_NONE;
      end else begin
         byte_index_ff  <= byte_index_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         old_buttons_ff <= old_buttons_in;
         press_ff       <= press_in;
      end
   end

   // Packet bytes held until the packet closes
   always_ff @(posedge clock) begin
      if (take) begin
         if (byte_index_ff == BYTE_MOVE_X) begin
            b1_ff <= s1_byte_ff;
         end else if (byte_index_ff != BYTE_MOVE_Y) begin
            b0_ff <= s1_byte_ff;
         end
      end
   end

   // Result register
   assign rsp_valid_in = (take && closes) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && closes) begin
         rsp_data_ff <= RspWidth'({old_buttons_in, press_in, pos_y_in, pos_x_in});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/pmc_axis.sv
// ----------------------------------------------------------------------------
// pmc_axis - one cursor axis: move and clamp
// Adds a signed movement to the position and clamps the sum to
// 0..limit, the limit being the screen size less a margin, held
// within 0..2^CoordWidth-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmc_axis
   import pmc_pkg::*;
#(
   parameter int CoordWidth = PMC_COORD_WIDTH,
   parameter int Margin     = PMC_X_MARGIN
) (
   input  wire logic [CoordWidth-1:0] pos_i,
   input  wire delta_type             delta_i,
   input  wire logic [SIZE_WIDTH-1:0] size_i,
   output logic      [CoordWidth-1:0] pos_o
);

   // Signed working width: covers the size, the position and a sign
   localparam int SumWidth = ((CoordWidth > SIZE_WIDTH) ? CoordWidth : SIZE_WIDTH) + 3;

   localparam logic signed [SumWidth-1:0] CoordMax =
      {{(SumWidth - CoordWidth){1'b0}}, {CoordWidth{1'b1}}};
   localparam logic signed [SumWidth-1:0] MarginS = SumWidth'(Margin);

   logic signed [SumWidth-1:0] lim_raw;
   logic signed [SumWidth-1:0] lim;
   logic signed [SumWidth-1:0] sum;
   logic signed [SumWidth-1:0] clamped;

   // Limit from the screen size
   always_comb begin
      lim_raw = $signed({{(SumWidth - SIZE_WIDTH){1'b0}}, size_i}) - MarginS;
      if (lim_raw < 0) begin
         lim = '0;
      end else if (lim_raw > CoordMax) begin
         lim = CoordMax;
      end else begin
         lim = lim_raw;
      end
   end

   // Move and clamp
   always_comb begin
      sum = $signed({{(SumWidth - CoordWidth){1'b0}}, pos_i})
            + SumWidth'(delta_i);
      if (sum < 0) begin
         clamped = '0;
      end else if (sum >= lim) begin
         clamped = lim;
      end else begin
         clamped = sum;
      end
   end

   assign pos_o = clamped[CoordWidth-1:0];

endmodule

`default_nettype wire
